/* src/stwf_pkg.sv */
// stwf_pkg: shared constants, types and the sine table for the sine tone generator.
// No dependencies; every other file imports this package.
`default_nettype none

package stwf_pkg;

  // Tone and table geometry
  localparam int TONE_SAMPLES   = 4800;
  localparam int SAMPLE_RATE_HZ = 16000;
  localparam int SINE_DEPTH     = 1024;

  // Field widths
  localparam int FREQ_W   = 13;
  localparam int PEAK_W   = 15;
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 32;
  localparam int INDEX_W  = 13;

  // Input item modes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(16000);

  // Sine table addressing
  localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
  localparam int SINE_DEPTH_W = $clog2(SINE_DEPTH + 1);

  // Fade-out: amp = floor(peak * (TONE_SAMPLES - i) * 5 / TONE_SAMPLES) for i > FADE_START.
  // The divide is an exact multiply by a rounded-up reciprocal.
  localparam int     FADE_START   = (TONE_SAMPLES * 4) / 5;
  localparam int     FADE_SPAN    = TONE_SAMPLES - FADE_START;
  localparam int     DIST_W       = $clog2(FADE_SPAN * 5 + 1);
  localparam longint FADE_NUM_MAX = longint'(32767) * 5 * FADE_SPAN;
  localparam int     FADE_NUM_W   = $clog2(FADE_NUM_MAX + 1);
  localparam int     FADE_SHIFT   = FADE_NUM_W + $clog2(TONE_SAMPLES);
  localparam longint FADE_RECIP   =
    ((longint'(1) << FADE_SHIFT) + TONE_SAMPLES - 1) / TONE_SAMPLES;
  localparam int     RECIP_W      = $clog2(FADE_RECIP + 1);
  localparam int     FPROD_W      = (FADE_NUM_W + RECIP_W > FADE_SHIFT + PEAK_W) ?
                                    (FADE_NUM_W + RECIP_W) : (FADE_SHIFT + PEAK_W);

  // Phase increment: 2^32 = INC_WHOLE * rate + INC_FRAC, so
  // inc = freq * INC_WHOLE + floor((freq * INC_FRAC + rate/2) / rate),
  // the last divide again an exact reciprocal multiply.
  localparam longint INC_WHOLE   = (longint'(1) << PHASE_W) / SAMPLE_RATE_HZ;
  localparam longint INC_FRAC    = (longint'(1) << PHASE_W) % SAMPLE_RATE_HZ;
  localparam int     INC_WHOLE_W = $clog2(INC_WHOLE + 1);
  localparam int     INC_FRAC_W  = (INC_FRAC > 0) ? $clog2(INC_FRAC + 1) : 1;
  localparam longint INC_Y_MAX   =
    ((longint'(1) << FREQ_W) - 1) * INC_FRAC + SAMPLE_RATE_HZ / 2;
  localparam int     INC_Y_W     = $clog2(INC_Y_MAX + 1);
  localparam int     INC_SHIFT   = INC_Y_W + $clog2(SAMPLE_RATE_HZ);
  localparam longint INC_RECIP   =
    ((longint'(1) << INC_SHIFT) + SAMPLE_RATE_HZ - 1) / SAMPLE_RATE_HZ;
  localparam int     INC_RECIP_W = $clog2(INC_RECIP + 1);
  localparam int     INC_PROD_W  = INC_Y_W + INC_RECIP_W;

  // Per-tone state word kept in the state memory
  typedef struct packed {
    logic               playing;
    logic [INDEX_W-1:0] index;
    logic [PHASE_W-1:0] inc;
    logic [PHASE_W-1:0] acc;
  } state_word_t;

  typedef struct packed {
    logic        en;
    state_word_t data;
  } ram_wr_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] freq;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [PHASE_W-1:0] quot;
  } div_rsp_t;

  // Sine table, Q1.15, built at elaboration by a Q30 Taylor series
  typedef logic signed [SAMPLE_W-1:0] sine_tab_t [SINE_DEPTH];

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
    longint unsigned a;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum_pos;
    longint unsigned sum_neg;
    longint unsigned mag;
    longint unsigned v;
    logic            neg;
    logic [SAMPLE_W-1:0] r;
    a   = (64'(k) * TWO_PI_Q30) / SINE_DEPTH;
    neg = 1'b0;
    if (a >= PI_Q30) begin
      neg = 1'b1;
      a   = a - PI_Q30;
    end
    if (a > HALF_PI_Q30) a = (a >= PI_Q30) ? 64'd0 : PI_Q30 - a;
    x2      = (a * a) >> 30;
    term    = a;
    sum_pos = a;
    sum_neg = 64'd0;
    term    = ((term * x2) >> 30) / 6;
    sum_neg = sum_neg + term;
    term    = ((term * x2) >> 30) / 20;
    sum_pos = sum_pos + term;
    term    = ((term * x2) >> 30) / 42;
    sum_neg = sum_neg + term;
    term    = ((term * x2) >> 30) / 72;
    sum_pos = sum_pos + term;
    term    = ((term * x2) >> 30) / 110;
    sum_neg = sum_neg + term;
    term    = ((term * x2) >> 30) / 156;
    sum_pos = sum_pos + term;
    mag = (sum_pos > sum_neg) ? (sum_pos - sum_neg) : 64'd0;
    v   = (mag * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    r = SAMPLE_W'(v);
    return neg ? (SAMPLE_W'(0) - r) : r;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    for (int k = 0; k < SINE_DEPTH; k++) t[k] = sine_entry(k);
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

`default_nettype wire

/* src/stwf_if.sv */
// Channel interfaces of the sine tone generator: input items, result items, config writes.
// Depends on stwf_pkg for field widths.
`default_nettype none

interface stwf_in_if import stwf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [FREQ_W-1:0] freq_hz;

  modport source (output valid, output mode, output freq_hz, input ready);
  modport sink   (input valid, input mode, input freq_hz, output ready);
endinterface

interface stwf_out_if import stwf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

interface stwf_cfg_if import stwf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] peak_amplitude;

  modport source (output valid, output peak_amplitude, input ready);
  modport sink   (input valid, input peak_amplitude, output ready);
endinterface

`default_nettype wire

/* src/stwf_state_ram.sv */
// stwf_state_ram: synchronous state memory holding the tone state word, registered read.
// Depends on stwf_pkg (state_word_t, ram_wr_t); a valid bit makes it read as zero after reset.
`default_nettype none

module stwf_state_ram import stwf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  ram_wr_t     ram_wr,
  output state_word_t rd_data_r
);

  localparam int STATE_DEPTH = 1;

  state_word_t mem [STATE_DEPTH];
  logic        valid_r;

  always_ff @(posedge clk) begin
    if (ram_wr.en) mem[0] <= ram_wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ram_wr.en) begin
      valid_r <= 1'b1;
    end
  end

  // never-written entry reads as the reset state
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= valid_r ? mem[0] : '0;
  end

endmodule

`default_nettype wire

/* src/stwf_sine_rom.sv */
// stwf_sine_rom: sine table with registered read data.
// Depends on stwf_pkg (SINE_TAB).
`default_nettype none

module stwf_sine_rom import stwf_pkg::*; (
  input  logic                       clk,
  input  logic [SINE_IDX_W-1:0]      addr,
  output logic signed [SAMPLE_W-1:0] rd_data_r
);

  always_ff @(posedge clk) begin
    rd_data_r <= SINE_TAB[addr];
  end

endmodule

`default_nettype wire

/* src/stwf_inc_div.sv */
// stwf_inc_div: reciprocal-multiply unit for the phase increment.
// Depends on stwf_pkg; quotient is round(freq * 2^32 / rate) modulo 2^32.
`default_nettype none

module stwf_inc_div import stwf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  logic [PHASE_W-1:0]    base_r, base_nxt;
  logic [INC_Y_W-1:0]    y_r,    y_nxt;
  logic [PHASE_W-1:0]    quot_r, quot_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [INC_PROD_W-1:0] y_prod;

  always_comb begin
    // split the dividend into a whole part and a small remainder part
    base_nxt = div_req.freq * INC_WHOLE_W'(INC_WHOLE);
    y_nxt    = div_req.freq * INC_FRAC_W'(INC_FRAC) + INC_Y_W'(SAMPLE_RATE_HZ / 2);
    y_prod   = y_r * INC_RECIP_W'(INC_RECIP);
    quot_nxt = base_r + PHASE_W'(y_prod[INC_PROD_W-1:INC_SHIFT]);
    busy_nxt = div_req.start && !busy_r;
    done_nxt = busy_r;
  end

  always_ff @(posedge clk) begin
    if (div_req.start && !busy_r) begin
      base_r <= base_nxt;
      y_r    <= y_nxt;
    end
    if (busy_r) quot_r <= quot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign div_rsp.busy = busy_r;
  assign div_rsp.done = done_r;
  assign div_rsp.quot = quot_r;

endmodule

`default_nettype wire

/* src/sine_tone_with_fade_out.sv */
// sine_tone_with_fade_out: DDS sine beep with linear fade-out, one sample per input item.
// Depends on stwf_pkg, stwf_if, stwf_state_ram, stwf_sine_rom and stwf_inc_div.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------
//  in_ch    | in  | valid/ready      | mode, freq_hz
//  out_ch   | out | valid/ready      | sample, last, active
//  cfg_ch   | in  | valid/ready (=1) | peak_amplitude
//
// A tick item passes through four steps: accept with state read, phase/table lookup and fade
// numerator, reciprocal multiply for the fade amplitude, then the sample multiply.
// A start item adds a wait in S_DIV for the reciprocal unit that forms the phase increment.
// One item is in flight at a time; a result held on out_ch stalls only the last stage.
// Synchronous active-low reset; the state memory reads as zero until first written.
`default_nettype none

module sine_tone_with_fade_out import stwf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stwf_in_if.sink    in_ch,
  stwf_out_if.source out_ch,
  stwf_cfg_if.sink   cfg_ch
);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_LOAD, S_FADE, S_OUT} fsm_t;

  fsm_t                       state_r;
  logic                       start_r;
  logic [PEAK_W-1:0]          peak_r;
  logic                       fade_r;
  logic                       last_r;
  logic                       active_r;
  logic [FADE_NUM_W-1:0]      x_r;
  logic [PEAK_W-1:0]          q_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_last_r;
  logic                       out_active_r;

  logic                       accept;
  state_word_t                ram_rd_data;
  state_word_t                cur;
  ram_wr_t                    ram_wr;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic [PHASE_W+SINE_DEPTH_W-1:0] sine_prod;
  logic [SINE_IDX_W-1:0]      sine_addr;
  logic signed [SAMPLE_W-1:0] tv;
  logic                       is_last;
  logic [INDEX_W-1:0]         remain;
  logic [DIST_W-1:0]          dist5;
  logic [PEAK_W+DIST_W-1:0]   x_full;
  logic [FADE_NUM_W-1:0]      x_nxt;
  logic [FPROD_W-1:0]         fprod;
  logic [PEAK_W-1:0]          q_nxt;
  logic                       neg;
  logic [PEAK_W-1:0]          tv_abs;
  logic [PEAK_W-1:0]          amp;
  logic [2*PEAK_W-1:0]        mag_prod;
  logic [SAMPLE_W-1:0]        mag_ext;
  logic [SAMPLE_W-1:0]        sample_nxt;
  logic                       out_free;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign div_req.start = accept && (in_ch.mode == MODE_START);
  assign div_req.freq  = in_ch.freq_hz;

  stwf_state_ram u_state_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .ram_wr    (ram_wr),
    .rd_data_r (ram_rd_data)
  );

  stwf_inc_div u_inc_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  stwf_sine_rom u_sine_rom (
    .clk       (clk),
    .addr      (sine_addr),
    .rd_data_r (tv)
  );

  always_comb begin
    // a start item replaces the stored state with a fresh tone
    if (start_r) begin
      cur.playing = 1'b1;
      cur.index   = '0;
      cur.inc     = div_rsp.quot;
      cur.acc     = '0;
    end else begin
      cur = ram_rd_data;
    end

    sine_prod = cur.acc * SINE_DEPTH_W'(SINE_DEPTH);
    sine_addr = sine_prod[PHASE_W +: SINE_IDX_W];

    is_last = (cur.index >= INDEX_W'(TONE_SAMPLES - 1));
    remain  = INDEX_W'(TONE_SAMPLES) - cur.index;
    dist5   = DIST_W'(remain * INDEX_W'(5));
    x_full  = peak_r * dist5;
    x_nxt   = FADE_NUM_W'(x_full);

    ram_wr.en           = (state_r == S_LOAD) && cur.playing;
    ram_wr.data.acc     = cur.acc + cur.inc;
    ram_wr.data.inc     = cur.inc;
    ram_wr.data.index   = is_last ? '0 : cur.index + INDEX_W'(1);
    ram_wr.data.playing = !is_last;

    fprod = x_r * RECIP_W'(FADE_RECIP);
    q_nxt = fprod[FADE_SHIFT +: PEAK_W];

    neg        = tv[SAMPLE_W-1];
    tv_abs     = neg ? PEAK_W'(SAMPLE_W'(0) - tv) : tv[PEAK_W-1:0];
    amp        = fade_r ? q_r : peak_r;
    mag_prod   = tv_abs * amp;
    mag_ext    = {1'b0, mag_prod[2*PEAK_W-1:PEAK_W]};
    sample_nxt = !active_r ? '0 : (neg ? (SAMPLE_W'(0) - mag_ext) : mag_ext);

    out_free = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      peak_r      <= PEAK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) peak_r <= cfg_ch.peak_amplitude;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            start_r <= (in_ch.mode == MODE_START);
            state_r <= (in_ch.mode == MODE_START) ? S_DIV : S_LOAD;
          end
        end
        S_DIV: begin
          if (div_rsp.done) state_r <= S_LOAD;
        end
        S_LOAD: begin
          fade_r   <= (cur.index > INDEX_W'(FADE_START));
          x_r      <= x_nxt;
          last_r   <= is_last;
          active_r <= cur.playing;
          state_r  <= S_FADE;
        end
        S_FADE: begin
          q_r     <= q_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register frees up
          if (out_free) begin
            out_sample_r <= sample_nxt;
            out_last_r   <= active_r && last_r;
            out_active_r <= active_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.last   = out_last_r;
  assign out_ch.active = out_active_r;

`ifndef SYNTHESIS
  a_no_write_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.busy |-> !ram_wr.en)
    else $error("state memory written while increment divider busy");

  a_start_runs_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.mode == MODE_START)) |=> div_rsp.busy)
    else $error("start item did not launch the increment divider");

  a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_ch.valid || out_ch.ready)) |=> (out_ch.valid && state_r == S_IDLE))
    else $error("finished item not presented on out_ch");

  a_write_only_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.en |=> (state_r == S_FADE))
    else $error("state write outside the load step");
`endif

endmodule

`default_nettype wire

/* tb/tb_sine_tone_with_fade_out.sv */
// tb_sine_tone_with_fade_out: self-checking bench for the DDS sine tone with fade-out.
// Depends on stwf_pkg, stwf_if and sine_tone_with_fade_out; a local Q1.15 tone model scores
// every unpinned sample of a directed table and random tone bursts under random stalls.
`default_nettype none

module tb_sine_tone_with_fade_out;
  import stwf_pkg::*;

  localparam int FADE_FROM   = (TONE_SAMPLES * 4) / 5;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       active;
  } tone_out_t;

  typedef struct packed {
    logic                       mode;
    logic [FREQ_W-1:0]          freq;
    logic                       pinned;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       active;
  } step_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;
  bit   steady = 1'b0;

  stwf_in_if  in_ch ();
  stwf_out_if out_ch ();
  stwf_cfg_if cfg_ch ();

  assign out_ch.ready = sink_ready;

  sine_tone_with_fade_out u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tone model state
  logic signed [SAMPLE_W-1:0] q15_sine [SINE_DEPTH];
  logic [PHASE_W-1:0]         tone_phase = '0;
  logic [PHASE_W-1:0]         tone_step  = '0;
  int                         tone_pos   = 0;
  bit                         tone_on    = 1'b0;
  logic [PEAK_W-1:0]          peak_now   = PEAK_W'(16000);

  tone_out_t expected_samples [$];
  tone_out_t want_now;

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int tones_started = 0;
  int peak_writes   = 0;
  int stall_cycles  = 0;

  // Directed items; a pinned row carries a value read straight off the tone definition
  step_row_t dir_table [24] = '{
    '{MODE_TICK,  FREQ_W'(0),    1'b1, 16'sd0,      1'b0, 1'b0},
    '{MODE_TICK,  FREQ_W'(8191), 1'b1, 16'sd0,      1'b0, 1'b0},
    '{MODE_START, FREQ_W'(0),    1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(5),    1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(8191), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_START, FREQ_W'(4000), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(0),    1'b1, 16'sd15999,  1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(8191), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(0),    1'b1, -16'sd15999, 1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(8191), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_START, FREQ_W'(8000), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(0),    1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_START, FREQ_W'(8191), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(0),    1'b0, 16'sd0,      1'b0, 1'b0},
    '{MODE_TICK,  FREQ_W'(8191), 1'b0, 16'sd0,      1'b0, 1'b0},
    '{MODE_START, FREQ_W'(1),    1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(0),    1'b0, 16'sd0,      1'b0, 1'b0},
    '{MODE_START, FREQ_W'(5461), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(2730), 1'b0, 16'sd0,      1'b0, 1'b0},
    '{MODE_TICK,  FREQ_W'(5461), 1'b0, 16'sd0,      1'b0, 1'b0},
    '{MODE_START, FREQ_W'(2730), 1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(0),    1'b0, 16'sd0,      1'b0, 1'b0},
    '{MODE_START, FREQ_W'(300),  1'b1, 16'sd0,      1'b0, 1'b1},
    '{MODE_TICK,  FREQ_W'(8191), 1'b0, 16'sd0,      1'b0, 1'b0}
  };

  // Q1.15 sine entry from a Q30 Taylor series, folded into the first quadrant
  function automatic logic signed [SAMPLE_W-1:0] taylor_sine(input int k);
    longint unsigned ang, sq, term, pos, negsum, mag, v;
    bit lower;
    ang    = (64'(k) * TWO_PI_Q30) / 64'(SINE_DEPTH);
    lower  = 1'b0;
    if (ang >= PI_Q30) begin
      lower = 1'b1;
      ang   = ang - PI_Q30;
    end
    if (ang > HALF_PI_Q30) ang = (ang >= PI_Q30) ? 64'd0 : PI_Q30 - ang;
    sq     = (ang * ang) >> 30;
    term   = ang;
    pos    = ang;
    negsum = 64'd0;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) negsum = negsum + term;
      else pos = pos + term;
    end
    mag = (pos > negsum) ? pos - negsum : 64'd0;
    v   = (mag * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return lower ? SAMPLE_W'(64'd0 - v) : SAMPLE_W'(v);
  endfunction

  task automatic predict_sample(input logic m, input logic [FREQ_W-1:0] f,
                                output tone_out_t r);
    longint unsigned amp, mag;
    int idx;
    int tv_abs;
    logic signed [SAMPLE_W-1:0] tv;
    r = '0;
    if (m == MODE_START) begin
      tone_step  = PHASE_W'(((64'(f) << 32) + 64'(SAMPLE_RATE_HZ / 2)) /
                            64'(SAMPLE_RATE_HZ));
      tone_phase = '0;
      tone_pos   = 0;
      tone_on    = 1'b1;
    end
    if (tone_on) begin
      idx    = int'((64'(tone_phase) * 64'(SINE_DEPTH)) >> 32);
      tv     = q15_sine[idx];
      tv_abs = (tv < 0) ? -int'(tv) : int'(tv);
      amp    = 64'(peak_now);
      // linear fade over the last fifth of the tone
      if (tone_pos > FADE_FROM)
        amp = (64'(peak_now) * 64'(TONE_SAMPLES - tone_pos) * 64'd5) / 64'(TONE_SAMPLES);
      mag      = (64'(tv_abs) * amp) >> 15;
      r.sample = (tv < 0) ? SAMPLE_W'(64'd0 - mag) : SAMPLE_W'(mag);
      r.last   = (tone_pos + 1 >= TONE_SAMPLES);
      r.active = 1'b1;
      tone_phase = tone_phase + tone_step;
      if (r.last) begin
        tone_on  = 1'b0;
        tone_pos = 0;
      end else begin
        tone_pos = tone_pos + 1;
      end
    end
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return FREQ_W'(0);
      1:       return FREQ_W'(8000);
      2:       return FREQ_W'(8191);
      3:       return FREQ_W'($urandom_range(1, 20));
      4, 5, 6: return FREQ_W'($urandom_range(0, 8000));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  function automatic void report_mismatch(input string field, input int want, input int got);
    error_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  task automatic send_item(input logic m, input logic [FREQ_W-1:0] f,
                           input bit pinned = 1'b0, input tone_out_t pinned_val = '0);
    tone_out_t want;
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= m;
    in_ch.freq_hz <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_sample(m, f, want);
    expected_samples.push_back(pinned ? pinned_val : want);
    items_sent++;
    if (m == MODE_START) tones_started++;
  endtask

  // Hold the sender until every pending sample has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  task automatic write_peak(input logic [PEAK_W-1:0] v);
    drain_results();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.peak_amplitude <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    peak_now = v;
    peak_writes++;
  endtask

  task automatic tone_burst(input int ticks, input logic [FREQ_W-1:0] f);
    send_item(MODE_START, f);
    for (int i = 0; i < ticks; i++) send_item(MODE_TICK, FREQ_W'($urandom));
  endtask

  task automatic run_random(input int n);
    int done_cnt;
    int run_len;
    done_cnt = 0;
    while (done_cnt < n) begin
      if ($urandom_range(0, 99) < 80) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 40);
        tone_burst(run_len, pick_freq());
        done_cnt += run_len + 1;
      end else begin
        // noise: stray starts and ticks in any order
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++)
          send_item(($urandom_range(0, 3) == 0) ? MODE_START : MODE_TICK, FREQ_W'($urandom));
        done_cnt += run_len;
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // Result checker and sink-side stalls
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        $error("result with no pending item: sample %0d", out_ch.sample);
      end else begin
        want_now = expected_samples.pop_front();
        if (out_ch.sample !== want_now.sample)
          report_mismatch("sample", $signed(want_now.sample), out_ch.sample);
        if (out_ch.last !== want_now.last)
          report_mismatch("last", want_now.last, out_ch.last);
        if (out_ch.active !== want_now.active)
          report_mismatch("active", want_now.active, out_ch.active);
        results_seen++;
      end
    end
    sink_ready <= rst_n && (steady || $urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.mode            = MODE_TICK;
    in_ch.freq_hz         = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.peak_amplitude = '0;
    for (int k = 0; k < SINE_DEPTH; k++) q15_sine[k] = taylor_sine(k);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[r])
      send_item(dir_table[r].mode, dir_table[r].freq, dir_table[r].pinned,
                tone_out_t'{dir_table[r].sample, dir_table[r].last, dir_table[r].active});
    run_random(300);

    // full scale, first with no idling on either side, then with random stalls again
    write_peak(PEAK_W'(32767));
    steady = 1'b1;
    run_random(250);
    steady = 1'b0;
    run_random(150);

    write_peak(PEAK_W'(0));
    run_random(150);

    write_peak(PEAK_W'(1));
    run_random(100);

    write_peak(PEAK_W'($urandom_range(2, 32766)));
    run_random(150);

    drain_results();
    repeat (60) @(posedge clk);

    $display("Covered %0d items and %0d samples over %0d peak settings after reset;",
             items_sent, results_seen, peak_writes);
    $display("%0d tone starts mixed with idle ticks, restarts and stalls on both sides.",
             tones_started);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* sine_tone_with_fade_out.f */
src/stwf_pkg.sv
src/stwf_if.sv
src/stwf_state_ram.sv
src/stwf_sine_rom.sv
src/stwf_inc_div.sv
src/sine_tone_with_fade_out.sv
tb/tb_sine_tone_with_fade_out.sv
